// ----- rtl/core/gnfo_pkg.sv -----
// gnfo_pkg: shared constants, widths and gradient functions for the fractal noise engine
// no dependencies
package gnfo_pkg;

  localparam int TABLE_SIZE  = 256;
  localparam int MAX_OCTAVES = 8;
  localparam int TAW         = $clog2(TABLE_SIZE);
  localparam int HASH_W      = (TAW > 10) ? TAW : 10;
  localparam int OCT_W       = $clog2(MAX_OCTAVES + 1);
  localparam int ONE_Q16     = 65536;
  localparam int TOT_W       = $clog2(MAX_OCTAVES * ONE_Q16 + 1);
  localparam int GW          = 20;
  localparam int SUM_W       = GW + 17 + OCT_W + 1;
  localparam int MA_W        = 33;
  localparam int MB_W        = 25;
  localparam int PW          = MA_W + MB_W;
  localparam int CW          = 18;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_DIMENSIONS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LACUNARITY   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PERSISTENCE  = 2'd3;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  localparam logic [1:0] DIM_FLAT = 2'd2;

  function automatic logic signed [GW-1:0] grad3(input logic [7:0] h,
                                                 input logic signed [CW-1:0] x,
                                                 input logic signed [CW-1:0] y,
                                                 input logic signed [CW-1:0] z);
    logic [3:0] hh;
    logic signed [GW-1:0] u;
    logic signed [GW-1:0] v;
    hh = h[3:0];
    u = (hh < 4'd8) ? GW'(x) : GW'(y);
    if (hh < 4'd4) v = GW'(y);
    else if (hh == 4'd12 || hh == 4'd14) v = GW'(x);
    else v = GW'(z);
    return (hh[0] ? -u : u) + (hh[1] ? -v : v);
  endfunction

  function automatic logic signed [GW-1:0] grad2(input logic [7:0] h,
                                                 input logic signed [CW-1:0] x,
                                                 input logic signed [CW-1:0] y);
    logic [2:0] hh;
    logic signed [GW-1:0] u;
    logic signed [GW-1:0] v;
    hh = h[2:0];
    u = (hh < 3'd4) ? GW'(x) : GW'(y);
    v = (hh < 3'd4) ? GW'(y) : GW'(x);
    return (hh[0] ? -u : u) + (hh[1] ? -(v <<< 1) : (v <<< 1));
  endfunction

endpackage

// ----- rtl/core/gradient_noise_fractal_octaves.sv -----
// gradient_noise_fractal_octaves: fractal gradient noise engine, 2D or 3D, top level
// depends on gnfo_pkg, gnfo_perm_ram, gnfo_mul, gnfo_div
//
//  channel   direction  handshake              payload
//  request   in         start, busy            func, table_index, table_value, x/y/z_coord
//  result    out        done (one-cycle pulse) noise_value
//  config    in         cfg_write              cfg_index, cfg_data
//
// a table load gives no result
// an evaluation works through each octave in turn, then performs the
// final division; each octave step uses the one shared multiplier or the table port
// busy is high from the accepted request until the cycle done pulses
// the result cannot be held off; rst is synchronous and needs no clearing pass
module gradient_noise_fractal_octaves (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            func,
  input  logic [7:0]                      table_index,
  input  logic [7:0]                      table_value,
  input  logic signed [31:0]              x_coord,
  input  logic signed [31:0]              y_coord,
  input  logic signed [31:0]              z_coord,
  output logic                            done,
  output logic signed [20:0]              noise_value,
  input  logic                            cfg_write,
  input  logic [gnfo_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gnfo_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gnfo_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SCALE, S_FT2, S_FT3, S_FB, S_FO, S_LOOK, S_MIX,
    S_ACC, S_AMP, S_FREQ, S_DIV, S_WAIT
  } state_t;

  state_t state;
  logic   ph;
  logic [3:0] k;

  logic [1:0]  dimensions;
  logic [3:0]  octave_count;
  logic [23:0] lacunarity;
  logic [16:0] persistence;

  logic signed [31:0] coord [3];
  logic [7:0]   lat_cell [3];
  logic [15:0]  frac [3];
  logic signed [CW-1:0] fade [3];
  logic [16:0]  t2;
  logic [16:0]  t3;
  logic signed [21:0] bq;
  logic [HASH_W-1:0] ha, hb, haa, hab, hba, hbb;
  logic signed [GW-1:0] g [8];
  logic [23:0]  freq;
  logic [16:0]  amp;
  logic [TOT_W-1:0] total;
  logic signed [SUM_W-1:0] sum;
  logic [OCT_W-1:0] oct;
  logic [OCT_W-1:0] oct_lim;
  logic flat;

  logic signed [MA_W-1:0] ma;
  logic signed [MB_W-1:0] mb;
  logic signed [PW-1:0]   prod;
  logic [TAW-1:0] raddr;
  logic [7:0]     rdata;
  logic           ram_we;

  logic div_start, div_done;
  logic [SUM_W-1:0] div_mag, div_q;
  logic signed [SUM_W:0] res_s;
  logic signed [20:0]    res_sat;

  logic [15:0] tcur;
  logic signed [21:0] fa;
  logic signed [GW-1:0] mix_a, mix_b;
  logic signed [GW:0]   mix_d;
  logic signed [CW-1:0] mix_t;
  logic [2:0] mix_dst;
  logic [2:0] ci;
  logic signed [CW-1:0] kx, ky, kz;
  logic [HASH_W-1:0] base;
  logic [HASH_W-1:0] laddr;

  gnfo_perm_ram u_ram (
    .clk(clk), .we(ram_we), .waddr(TAW'(table_index)), .wdata(table_value),
    .raddr(raddr), .rdata(rdata)
  );

  gnfo_mul u_mul (.clk(clk), .ma(ma), .mb(mb), .prod(prod));

  gnfo_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_mag),
    .divisor(total), .done(div_done), .quotient(div_q)
  );

  assign busy      = (state != S_IDLE);
  assign ram_we    = start && !busy && (func == FUNC_LOAD) && (int'(table_index) < TABLE_SIZE);
  assign div_start = (state == S_DIV);
  assign div_mag   = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

  always_comb begin
    if (octave_count == '0) oct_lim = OCT_W'(1);
    else if (int'(octave_count) > MAX_OCTAVES) oct_lim = OCT_W'(MAX_OCTAVES);
    else oct_lim = OCT_W'(octave_count);
  end

  always_comb begin
    res_s = sum[SUM_W-1] ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
    if (res_s > $signed((SUM_W+1)'(1048575))) res_sat = 21'sh0FFFFF;
    else if (res_s < -$signed((SUM_W+1)'(1048576))) res_sat = -21'sh100000;
    else res_sat = 21'(res_s);
  end

  // corner of the cell for the current gradient lookup
  always_comb begin
    ci = 3'(k - 4'd6);
    kx = ci[0] ? ($signed({2'b0, frac[0]}) - 18'sd65536) : $signed({2'b0, frac[0]});
    ky = ci[1] ? ($signed({2'b0, frac[1]}) - 18'sd65536) : $signed({2'b0, frac[1]});
    kz = ci[2] ? ($signed({2'b0, frac[2]}) - 18'sd65536) : $signed({2'b0, frac[2]});
    if (flat) begin
      base = (ci[0] ? hb : ha) + HASH_W'(ci[1]);
    end else begin
      case (ci[1:0])
        2'd0:    base = haa;
        2'd1:    base = hba;
        2'd2:    base = hab;
        default: base = hbb;
      endcase
      base = base + HASH_W'(ci[2]);
    end
    case (k)
      4'd0:    laddr = HASH_W'(lat_cell[0]);
      4'd1:    laddr = HASH_W'(lat_cell[0]) + HASH_W'(1);
      4'd2:    laddr = ha;
      4'd3:    laddr = ha + HASH_W'(1);
      4'd4:    laddr = hb;
      4'd5:    laddr = hb + HASH_W'(1);
      default: laddr = base;
    endcase
    raddr = TAW'(laddr);
  end

  always_comb begin
    case (k)
      4'd1:    begin mix_a = g[2]; mix_b = g[3]; mix_t = fade[0]; mix_dst = 3'd2; end
      4'd2:    begin mix_a = g[4]; mix_b = g[5]; mix_t = fade[0]; mix_dst = 3'd4; end
      4'd3:    begin mix_a = g[6]; mix_b = g[7]; mix_t = fade[0]; mix_dst = 3'd6; end
      4'd4:    begin mix_a = g[0]; mix_b = g[2]; mix_t = fade[1]; mix_dst = 3'd0; end
      4'd5:    begin mix_a = g[4]; mix_b = g[6]; mix_t = fade[1]; mix_dst = 3'd4; end
      4'd6:    begin mix_a = g[0]; mix_b = g[4]; mix_t = fade[2]; mix_dst = 3'd0; end
      default: begin mix_a = g[0]; mix_b = g[1]; mix_t = fade[0]; mix_dst = 3'd0; end
    endcase
    mix_d = $signed({mix_b[GW-1], mix_b}) - $signed({mix_a[GW-1], mix_a});
  end

  always_comb begin
    tcur = frac[k[1:0]];
    fa   = $signed({5'b0, tcur, 1'b0}) + $signed({4'b0, tcur, 2'b0}) - 22'sd983040;
    ma   = '0;
    mb   = '0;
    unique case (state)
      S_SCALE: begin ma = MA_W'(coord[k[1:0]]); mb = $signed({1'b0, freq}); end
      S_FT2:   begin ma = $signed({17'b0, tcur}); mb = $signed({9'b0, tcur}); end
      S_FT3:   begin ma = $signed({16'b0, t2}); mb = $signed({9'b0, tcur}); end
      S_FB:    begin ma = MA_W'(fa); mb = $signed({9'b0, tcur}); end
      S_FO:    begin ma = $signed({16'b0, t3}); mb = MB_W'(bq); end
      S_MIX:   begin ma = MA_W'(mix_d); mb = MB_W'(mix_t); end
      S_ACC:   begin ma = MA_W'(g[0]); mb = $signed({8'b0, amp}); end
      S_AMP:   begin ma = $signed({16'b0, amp}); mb = $signed({8'b0, persistence}); end
      S_FREQ:  begin ma = $signed({9'b0, freq}); mb = $signed({1'b0, lacunarity}); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dimensions   <= 2'd3;
      octave_count <= 4'd4;
      lacunarity   <= 24'd131072;
      persistence  <= 17'd32768;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_DIMENSIONS:   dimensions   <= cfg_data[1:0];
        CFG_OCTAVE_COUNT: octave_count <= cfg_data[3:0];
        CFG_LACUNARITY:   lacunarity   <= cfg_data;
        CFG_PERSISTENCE:  persistence  <= (cfg_data[16:0] > 17'd65536) ? 17'd65536
                                                                         : cfg_data[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ph    <= 1'b0;
      k     <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start && func == FUNC_EVAL) begin
            coord[0] <= x_coord;
            coord[1] <= y_coord;
            coord[2] <= z_coord;
            flat     <= (dimensions == DIM_FLAT);
            freq     <= 24'd65536;
            amp      <= 17'd65536;
            sum      <= '0;
            total    <= '0;
            oct      <= '0;
            k        <= '0;
            ph       <= 1'b0;
            state    <= S_SCALE;
          end
        end
        S_DIV: state <= S_WAIT;
        S_WAIT: begin
          if (div_done) begin
            noise_value <= res_sat;
            done        <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: begin
          if (!ph) begin
            ph <= 1'b1;
          end else begin
            ph <= 1'b0;
            unique case (state)
              S_SCALE: begin
                lat_cell[k[1:0]] <= prod[39:32];
                frac[k[1:0]] <= prod[31:16];
                if (k == 4'd2) begin
                  k <= '0;
                  state <= S_FT2;
                end else begin
                  k <= k + 4'd1;
                end
              end
              S_FT2: begin t2 <= prod[32:16]; state <= S_FT3; end
              S_FT3: begin t3 <= prod[32:16]; state <= S_FB; end
              S_FB: begin
                bq    <= $signed(prod[37:16]) + 22'sd655360;
                state <= S_FO;
              end
              S_FO: begin
                fade[k[1:0]] <= $signed(prod[33:16]);
                if (k == 4'd2) begin
                  k <= '0;
                  state <= S_LOOK;
                end else begin
                  k <= k + 4'd1;
                  state <= S_FT2;
                end
              end
              S_LOOK: begin
                case (k)
                  4'd0: ha  <= HASH_W'(rdata) + HASH_W'(lat_cell[1]);
                  4'd1: hb  <= HASH_W'(rdata) + HASH_W'(lat_cell[1]);
                  4'd2: haa <= HASH_W'(rdata) + HASH_W'(lat_cell[2]);
                  4'd3: hab <= HASH_W'(rdata) + HASH_W'(lat_cell[2]);
                  4'd4: hba <= HASH_W'(rdata) + HASH_W'(lat_cell[2]);
                  4'd5: hbb <= HASH_W'(rdata) + HASH_W'(lat_cell[2]);
                  default: g[ci] <= flat ? grad2(rdata, kx, ky) : grad3(rdata, kx, ky, kz);
                endcase
                if (flat && k == 4'd1) begin
                  k <= 4'd6;
                end else if ((flat && k == 4'd9) || k == 4'd13) begin
                  k <= '0;
                  state <= S_MIX;
                end else begin
                  k <= k + 4'd1;
                end
              end
              S_MIX: begin
                g[mix_dst] <= mix_a + $signed(prod[GW+15:16]);
                if (flat && k == 4'd1) begin
                  k <= 4'd4;
                end else if ((flat && k == 4'd4) || k == 4'd6) begin
                  k <= '0;
                  state <= S_ACC;
                end else begin
                  k <= k + 4'd1;
                end
              end
              S_ACC: begin
                sum   <= sum + SUM_W'(prod);
                total <= total + TOT_W'(amp);
                state <= S_AMP;
              end
              S_AMP: begin amp <= prod[32:16]; state <= S_FREQ; end
              S_FREQ: begin
                freq <= prod[39:16];
                if ((oct + OCT_W'(1)) == oct_lim) begin
                  state <= S_DIV;
                end else begin
                  oct   <= oct + OCT_W'(1);
                  k     <= '0;
                  state <= S_SCALE;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
      endcase
    end
  end

  a_done_from_div: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_WAIT && $past(div_done))
    else $error("result without finished division");

  a_eval_goes_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && func == FUNC_EVAL |=> busy)
    else $error("evaluate request not taken");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy && func == FUNC_LOAD |=> !done && !busy)
    else $error("table load produced a result");

  a_div_one_shot: assert property (@(posedge clk) disable iff (rst)
    div_start |=> !div_start && state == S_WAIT)
    else $error("division started twice");

endmodule

// ----- rtl/core/gnfo_perm_ram.sv -----
// gnfo_perm_ram: permutation table, one write port and one registered read port
// depends on gnfo_pkg
module gnfo_perm_ram (
  input  logic                    clk,
  input  logic                    we,
  input  logic [gnfo_pkg::TAW-1:0] waddr,
  input  logic [7:0]              wdata,
  input  logic [gnfo_pkg::TAW-1:0] raddr,
  output logic [7:0]              rdata
);
  import gnfo_pkg::*;

  logic [7:0] mem [TABLE_SIZE];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/gnfo_mul.sv -----
// gnfo_mul: shared signed multiplier with registered product
// depends on gnfo_pkg
module gnfo_mul (
  input  logic                            clk,
  input  logic signed [gnfo_pkg::MA_W-1:0] ma,
  input  logic signed [gnfo_pkg::MB_W-1:0] mb,
  output logic signed [gnfo_pkg::PW-1:0]   prod
);
  import gnfo_pkg::*;

  always_ff @(posedge clk) begin
    prod <= PW'(ma) * PW'(mb);
  end

endmodule

// ----- rtl/core/gnfo_div.sv -----
// gnfo_div: restoring divider, one quotient bit per cycle
// depends on gnfo_pkg
module gnfo_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [gnfo_pkg::SUM_W-1:0] dividend,
  input  logic [gnfo_pkg::TOT_W-1:0] divisor,
  output logic                       done,
  output logic [gnfo_pkg::SUM_W-1:0] quotient
);
  import gnfo_pkg::*;

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic             running;
  logic [CNT_W-1:0] cnt;
  logic [TOT_W:0]   rem;
  logic [TOT_W:0]   shifted;
  logic             fits;

  assign shifted = {rem[TOT_W-1:0], quotient[SUM_W-1]};
  assign fits    = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running  <= 1'b1;
        cnt      <= CNT_W'(SUM_W);
        rem      <= '0;
        quotient <= dividend;
      end else if (running) begin
        rem      <= fits ? (shifted - {1'b0, divisor}) : shifted;
        quotient <= {quotient[SUM_W-2:0], fits};
        cnt      <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- tb/gradient_noise_fractal_octaves_tb.sv -----
// gradient_noise_fractal_octaves_tb: self-checking bench for the fractal gradient noise engine
// loads the permutation table, runs directed and random requests under several settings
// depends on gnfo_pkg and gradient_noise_fractal_octaves
module gradient_noise_fractal_octaves_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gnfo_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic func = FUNC_LOAD;
  logic [7:0] table_index = '0;
  logic [7:0] table_value = '0;
  logic signed [31:0] x_coord = '0;
  logic signed [31:0] y_coord = '0;
  logic signed [31:0] z_coord = '0;
  logic done;
  logic signed [20:0] noise_value;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  gradient_noise_fractal_octaves DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .table_index(table_index), .table_value(table_value),
    .x_coord(x_coord), .y_coord(y_coord), .z_coord(z_coord),
    .done(done), .noise_value(noise_value),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [7:0] perm_tbl [TABLE_SIZE];
  logic [1:0] dim_reg;
  logic [3:0] oct_reg;
  logic [23:0] lac_reg;
  logic [16:0] pers_reg;

  logic signed [20:0] noise_q[$];
  int errors = 0;
  int idle_cycles = 0;

  typedef struct {
    logic f;
    logic [7:0] idx;
    logic [7:0] val;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    bit known;
    logic signed [20:0] noise;
  } req_t;

  function automatic longint fl16(longint v);
    return v >>> 16;
  endfunction

  function automatic longint fade_q16(longint t);
    longint t2, t3, a, b;
    t2 = fl16(t * t);
    t3 = fl16(t2 * t);
    a = 6 * t - 15 * 65536;
    b = fl16(a * t) + 10 * 65536;
    return fl16(t3 * b);
  endfunction

  function automatic longint blend(longint t, longint a, longint b);
    return a + fl16(t * (b - a));
  endfunction

  function automatic longint perm(longint i);
    return longint'(perm_tbl[i & 255]);
  endfunction

  function automatic longint grad_2d(longint hash, longint x, longint y);
    longint h, u, v;
    h = hash & 7;
    u = (h < 4) ? x : y;
    v = (h < 4) ? y : x;
    return (h[0] ? -u : u) + (h[1] ? -2 * v : 2 * v);
  endfunction

  function automatic longint grad_3d(longint hash, longint x, longint y, longint z);
    longint h, u, v;
    h = hash & 15;
    u = (h < 8) ? x : y;
    v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic void lattice(logic signed [31:0] coord, logic [23:0] freq,
                                  output longint lat_cell, output longint frac);
    logic [63:0] p;
    p = longint'(coord) * longint'({40'd0, freq});
    lat_cell = longint'(p[39:32]);
    frac = longint'(p[31:16]);
  endfunction

  function automatic longint noise_2d(longint cx, longint cy, longint fx, longint fy);
    longint u, v, a, b, gx1, gy1;
    u = fade_q16(fx);
    v = fade_q16(fy);
    a = perm(cx) + cy;
    b = perm(cx + 1) + cy;
    gx1 = fx - 65536;
    gy1 = fy - 65536;
    return blend(v, blend(u, grad_2d(perm(a), fx, fy), grad_2d(perm(b), gx1, fy)),
                 blend(u, grad_2d(perm(a + 1), fx, gy1), grad_2d(perm(b + 1), gx1, gy1)));
  endfunction

  function automatic longint noise_3d(longint c0, longint c1, longint c2,
                                      longint x0, longint y0, longint z0);
    longint u, v, w, a, aa, ab, b, ba, bb, x1, y1, z1, nr, fr;
    u = fade_q16(x0);
    v = fade_q16(y0);
    w = fade_q16(z0);
    a = perm(c0) + c1;
    aa = perm(a) + c2;
    ab = perm(a + 1) + c2;
    b = perm(c0 + 1) + c1;
    ba = perm(b) + c2;
    bb = perm(b + 1) + c2;
    x1 = x0 - 65536;
    y1 = y0 - 65536;
    z1 = z0 - 65536;
    nr = blend(v,
      blend(u, grad_3d(perm(aa), x0, y0, z0), grad_3d(perm(ba), x1, y0, z0)),
      blend(u, grad_3d(perm(ab), x0, y1, z0), grad_3d(perm(bb), x1, y1, z0)));
    fr = blend(v,
      blend(u, grad_3d(perm(aa + 1), x0, y0, z1), grad_3d(perm(ba + 1), x1, y0, z1)),
      blend(u, grad_3d(perm(ab + 1), x0, y1, z1), grad_3d(perm(bb + 1), x1, y1, z1)));
    return blend(w, nr, fr);
  endfunction

  function automatic logic signed [20:0] fbm_noise(logic signed [31:0] x,
                                                   logic signed [31:0] y,
                                                   logic signed [31:0] z);
    int octs;
    logic [23:0] freq;
    logic [47:0] fp;
    longint amp, total, acc, r, n, cx, cy, cz, fx, fy, fz;
    octs = (oct_reg < 1) ? 1 : ((oct_reg > MAX_OCTAVES) ? MAX_OCTAVES : int'(oct_reg));
    freq = 24'h010000;
    amp = 65536;
    total = 0;
    acc = 0;
    for (int i = 0; i < octs; i++) begin
      lattice(x, freq, cx, fx);
      lattice(y, freq, cy, fy);
      lattice(z, freq, cz, fz);
      n = (dim_reg == DIM_FLAT) ? noise_2d(cx, cy, fx, fy) : noise_3d(cx, cy, cz, fx, fy, fz);
      acc += amp * n;
      total += amp;
      amp = (amp * longint'(pers_reg)) >>> 16;
      fp = freq * lac_reg;
      freq = fp[39:16];
    end
    r = acc / total;
    if (r > 1048575) r = 1048575;
    if (r < -1048576) r = -1048576;
    return r[20:0];
  endfunction

  // result check and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("TEST FAILED");
        $finish;
      end
      if (done) begin
        if (noise_q.size() == 0) begin
          $error("noise_value: unexpected result %0d", noise_value);
          errors++;
        end else begin
          if (noise_value !== noise_q[0]) begin
            $error("noise_value: expected %0d, actual %0d", noise_q[0], noise_value);
            errors++;
          end
          void'(noise_q.pop_front());
        end
      end
    end
  end

  task automatic send(req_t r, int idle_pct);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    func <= r.f;
    table_index <= r.idx;
    table_value <= r.val;
    x_coord <= r.x;
    y_coord <= r.y;
    z_coord <= r.z;
    do @(posedge clk); while (busy);
    if (r.f == FUNC_LOAD) begin
      perm_tbl[r.idx] = r.val;
    end else begin
      if (r.known) noise_q = {noise_q, r.noise};
      else noise_q = {noise_q, fbm_noise(r.x, r.y, r.z)};
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (noise_q.size() != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic configure(logic [1:0] d, logic [3:0] o, logic [23:0] l, logic [16:0] p);
    logic [CFG_DATA_W-1:0] vals [4];
    logic [CFG_IDX_W-1:0] idxs [4];
    vals = '{CFG_DATA_W'(d), CFG_DATA_W'(o), l, CFG_DATA_W'(p)};
    idxs = '{CFG_DIMENSIONS, CFG_OCTAVE_COUNT, CFG_LACUNARITY, CFG_PERSISTENCE};
    for (int i = 0; i < 4; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    dim_reg = d;
    oct_reg = o;
    lac_reg = l;
    pers_reg = (p > 17'd65536) ? 17'd65536 : p;
  endtask

  function automatic logic signed [31:0] rand_coord();
    if ($urandom_range(1)) return $urandom;
    return $signed($urandom_range(32'h000C0000)) - 32'sh00060000;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    r.f = ($urandom_range(99) < 75) ? FUNC_EVAL : FUNC_LOAD;
    r.idx = 8'($urandom);
    r.val = 8'($urandom);
    r.x = rand_coord();
    r.y = rand_coord();
    r.z = rand_coord();
    r.known = 0;
    r.noise = '0;
    return r;
  endfunction

  req_t directed [$];
  req_t rq;
  int phase_n [6] = '{140, 100, 100, 100, 100, 150};
  int phase_idle [6] = '{0, 62, 0, 62, 32, 0};

  initial begin
    dim_reg = 2'd3;
    oct_reg = 4'd4;
    lac_reg = 24'd131072;
    pers_reg = 17'd32768;
    foreach (perm_tbl[i]) perm_tbl[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < TABLE_SIZE; i++) begin
      rq = '{FUNC_LOAD, 8'(i), 8'($urandom), 32'($urandom), 32'($urandom), 32'($urandom),
             0, '0};
      send(rq, (i < 128) ? 0 : 62);
    end

    // f, idx, val, x, y, z, known, noise
    directed = '{
      '{FUNC_EVAL, 8'd0, 8'd0, 32'sh0, 32'sh0, 32'sh0, 1, 21'sd0},
      '{FUNC_EVAL, 8'd0, 8'd0, 32'sh00010000, -32'sh00010000, 32'sh00050000, 1, 21'sd0},
      '{FUNC_EVAL, 8'd0, 8'd0, 32'sh7FFF0000, 32'sh80000000, 32'sh00FF0000, 1, 21'sd0},
      '{FUNC_EVAL, 8'd0, 8'd0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, '0},
      '{FUNC_EVAL, 8'd0, 8'd0, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0, '0},
      '{FUNC_EVAL, 8'd0, 8'd0, 32'sh0000FFFF, 32'sh00008000, 32'sh00000001, 0, '0},
      '{FUNC_EVAL, 8'd0, 8'd0, -32'sh00000001, -32'sh00008000, -32'sh0000FFFF, 0, '0},
      '{FUNC_EVAL, 8'd0, 8'd0, 32'sh00018000, 32'sh00FF8000, -32'sh00018000, 0, '0},
      '{FUNC_LOAD, 8'd0, 8'd255, 32'sh0, 32'sh0, 32'sh0, 0, '0},
      '{FUNC_LOAD, 8'd255, 8'd0, 32'shFFFFFFFF, 32'shFFFFFFFF, 32'shFFFFFFFF, 0, '0},
      '{FUNC_EVAL, 8'd255, 8'd255, 32'sh00FF4000, 32'sh00FFC000, 32'sh00004000, 0, '0},
      '{FUNC_LOAD, 8'd255, 8'd255, 32'sh0, 32'sh0, 32'sh0, 0, '0},
      '{FUNC_LOAD, 8'd1, 8'd0, 32'sh0, 32'sh0, 32'sh0, 0, '0},
      '{FUNC_EVAL, 8'd0, 8'd0, 32'sh00000000, 32'sh00FF0001, 32'sh5A5A5A5A, 0, '0},
      '{FUNC_EVAL, 8'd0, 8'd0, 32'shA5A5A5A5, 32'sh5A5A5A5A, 32'sh12345678, 0, '0},
      '{FUNC_EVAL, 8'd0, 8'd0, 32'sh0000C000, 32'sh00003000, 32'sh0000E000, 0, '0}
    };
    foreach (directed[i]) send(directed[i], 0);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: configure(2'd2, 4'd1, 24'd131072, 17'd32768);
        1: configure(2'd3, 4'd8, 24'hFFFFFF, 17'd65536);
        2: configure(2'd0, 4'd0, 24'd0, 17'd0);
        3: configure(2'd1, 4'd15, 24'd98304, 17'h1FFFF);
        4: configure(2'd2, 4'd8, 24'd0, 17'd65535);
        default: configure(2'($urandom_range(3)), 4'($urandom_range(1, 5)), 24'($urandom),
                           17'($urandom_range(17'h1FFFF)));
      endcase
      for (int i = 0; i < phase_n[ph]; i++) begin
        rq = rand_req();
        if (ph == 5 && i % 30 == 0) begin
          drain();
          configure(2'($urandom_range(2, 3)), 4'($urandom_range(1, 4)),
                    24'($urandom_range(24'h030000)), 17'($urandom_range(17'd65536)));
        end
        if (ph == 4) begin
          // hold each request until the previous result is back
          start <= 1'b0;
          @(posedge clk);
          while (noise_q.size() != 0) @(posedge clk);
        end
        send(rq, phase_idle[ph]);
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (noise_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/gnfo_pkg.sv
rtl/core/gnfo_perm_ram.sv
rtl/core/gnfo_mul.sv
rtl/core/gnfo_div.sv
rtl/core/gradient_noise_fractal_octaves.sv
tb/gradient_noise_fractal_octaves_tb.sv
